/* sv/bffa_pkg.sv */
`timescale 1ns / 1ps

package bffa_pkg;

   localparam int CELL_BITS     = 8;
   localparam int POS_W         = 8;
   localparam int CNT_W         = 9;
   localparam int LIM_W         = 9;
   localparam int MAPB_W        = 6;
   localparam logic [MAPB_W-1:0] MAP_BYTES_RST = 6'd32;

   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_ALLOC  = 2'd1,
      MODE_FREE   = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type         mode;
      logic [POS_W-1:0] start_req;
      logic [CNT_W-1:0] count;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } rsp_type;

   // request held for the whole pass down the chain
   typedef struct packed {
      mode_type         mode;
      logic [POS_W-1:0] start_req;
      logic [CNT_W-1:0] count;
      logic [LIM_W-1:0] lim;
   } item_type;

   // token handed from cell to cell
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [CNT_W-1:0] run;
      logic [POS_W-1:0] pos;
   } tok_type;

endpackage

/* sv/bitmap_first_fit_allocator.sv */
`timescale 1ns / 1ps
// Bitmap held in a row of 8-bit cells; a token walks one cell per cycle.
// One item in flight: req_stall holds a new request until the last result leaves the
// pending register, after the token's walk through the cell chain.
// Reset (synchronous, active high): every bit free, map_bytes = 32, no item pending.

module bitmap_first_fit_allocator #(
   parameter int MAP_BITS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bffa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bffa_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [bffa_pkg::MAPB_W-1:0] csr_wr_data
);

   localparam int NCELLS = (MAP_BITS + bffa_pkg::CELL_BITS - 1) / bffa_pkg::CELL_BITS;

   logic [bffa_pkg::MAPB_W-1:0] map_bytes_ff;
   bffa_pkg::item_type          item_ff;
   logic                        busy_ff;
   bffa_pkg::tok_type           inj_ff;
   bffa_pkg::tok_type           tok [NCELLS+1];
   logic                        pend_valid_ff;
   bffa_pkg::tok_type           pend_tok_ff;
   logic                        rsp_valid_ff;
   bffa_pkg::rsp_type           rsp_data_ff;
   bffa_pkg::rsp_type           rsp_data_in;

   logic req_accept;
   logic rsp_free;
   logic pend_move;

   assign req_accept = req_valid && !busy_ff;
   assign req_stall  = busy_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign pend_move  = pend_valid_ff && rsp_free;

   assign tok[0] = inj_ff;

   for (genvar k = 0; k < NCELLS; k++) begin : g_cell
      bffa_cell #(
         .MAP_BITS (MAP_BITS),
         .CELL_IDX (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .item    (item_ff),
         .tok_in  (tok[k]),
         .tok_out (tok[k+1])
      );
   end

   always_comb begin
      rsp_data_in = '0;
      unique case (item_ff.mode)
         bffa_pkg::MODE_SEARCH: begin
            rsp_data_in.found    = pend_tok_ff.hit;
            rsp_data_in.position = pend_tok_ff.hit ? pend_tok_ff.pos : '0;
         end
         bffa_pkg::MODE_ALLOC, bffa_pkg::MODE_FREE: begin
            rsp_data_in.found    = 1'b1;
            rsp_data_in.position = item_ff.start_req;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_bytes_ff  <= bffa_pkg::MAP_BYTES_RST;
         busy_ff       <= 1'b0;
         inj_ff.valid  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) map_bytes_ff <= csr_wr_data;
         if (req_accept)     busy_ff <= 1'b1;
         else if (pend_move) busy_ff <= 1'b0;
         inj_ff.valid <= req_accept;
         if (tok[NCELLS].valid) pend_valid_ff <= 1'b1;
         else if (pend_move)    pend_valid_ff <= 1'b0;
         if (pend_move)     rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (req_accept) begin
         item_ff.mode      <= req_data.mode;
         item_ff.start_req <= req_data.start_req;
         item_ff.count     <= req_data.count;
         item_ff.lim       <= {map_bytes_ff, 3'b000};
         // zero-length search is satisfied at index 0 before the walk starts
         inj_ff.hit        <= (req_data.mode == bffa_pkg::MODE_SEARCH) &&
                              (req_data.count == '0);
         inj_ff.run        <= '0;
         inj_ff.pos        <= '0;
      end
      if (tok[NCELLS].valid) pend_tok_ff <= tok[NCELLS];
      if (pend_move)         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0({inj_ff.valid, tok[NCELLS].valid, pend_valid_ff}))
      else $error("more than one item in flight");

   a_tail_busy: assert property (@(posedge clock) disable iff (reset)
      tok[NCELLS].valid |-> busy_ff)
      else $error("chain output without an item in progress");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> busy_ff)
      else $error("pending result while idle");

   a_accept_inject: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (inj_ff.valid && busy_ff))
      else $error("accepted item not launched into chain");

endmodule

/* sv/bffa_cell.sv */
`timescale 1ns / 1ps

module bffa_cell #(
   parameter int MAP_BITS = 256,
   parameter int CELL_IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  bffa_pkg::item_type item,
   input  bffa_pkg::tok_type tok_in,
   output bffa_pkg::tok_type tok_out
);

   localparam int AW = $clog2(MAP_BITS) + 1;
   localparam int CW = (AW > 10) ? AW : 10;

   logic [bffa_pkg::CELL_BITS-1:0] bits_ff;
   logic [bffa_pkg::CELL_BITS-1:0] bits_in;
   bffa_pkg::tok_type              tok_out_ff;
   bffa_pkg::tok_type              tok_out_in;

   always_comb begin
      logic [CW-1:0] idx;
      logic [CW-1:0] pos_full;
      logic          in_map;
      logic          in_rng;
      bits_in    = bits_ff;
      tok_out_in = tok_in;
      for (int j = 0; j < bffa_pkg::CELL_BITS; j++) begin
         idx      = CW'(CELL_IDX * bffa_pkg::CELL_BITS + j);
         in_map   = (idx < CW'(item.lim)) && (idx < CW'(MAP_BITS));
         in_rng   = (idx >= CW'(item.start_req)) &&
                    ((idx - CW'(item.start_req)) < CW'(item.count));
         pos_full = idx + CW'(1) - CW'(item.count);
         if (tok_in.valid) begin
            unique case (item.mode)
               bffa_pkg::MODE_ALLOC: begin
                  if (in_map && in_rng) bits_in[j] = 1'b1;
               end
               bffa_pkg::MODE_FREE: begin
                  if (in_map && in_rng) bits_in[j] = 1'b0;
               end
               bffa_pkg::MODE_SEARCH: begin
                  if (!tok_out_in.hit) begin
                     // bits past the active end count as taken
                     if (in_map && !bits_ff[j])
                        tok_out_in.run = tok_out_in.run + 1'b1;
                     else
                        tok_out_in.run = '0;
                     if (tok_out_in.run == item.count) begin
                        tok_out_in.hit = 1'b1;
                        tok_out_in.pos = pos_full[bffa_pkg::POS_W-1:0];
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff          <= '0;
         tok_out_ff.valid <= 1'b0;
      end else begin
         bits_ff          <= bits_in;
         tok_out_ff.valid <= tok_out_in.valid;
      end
      tok_out_ff.hit <= tok_out_in.hit;
      tok_out_ff.run <= tok_out_in.run;
      tok_out_ff.pos <= tok_out_in.pos;
   end

   assign tok_out = tok_out_ff;

endmodule
